/* src/smap_pkg.sv */
// Shared types, constants and color tables for the segment color mapper.
package smap_pkg;

	localparam int HEAT_STOPS    = 11;
	localparam int HEAT_IW       = $clog2(HEAT_STOPS);
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [2:0] {
		MODE_PREVIEW = 3'd0,
		MODE_ROLE    = 3'd1,
		MODE_TOOL    = 3'd2,
		MODE_HEAT    = 3'd3,
		MODE_FLOW    = 3'd4
	} mode_t;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_MIN  = 2'd1;
	localparam logic [1:0] CFG_MAX  = 2'd2;

	localparam logic [1:0] MOTION_TRAVEL = 2'd1;
	localparam logic [1:0] MOTION_WIPE   = 2'd2;

	localparam logic [15:0] TOOL_NONE = 16'hffff;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// color carried alongside the heat math
	typedef struct packed {
		logic heat;
		rgb_t rgb;
		logic ok;
	} side_t;

	function automatic rgb_t role_rgb(input logic [7:0] role, input logic [1:0] motion,
			input logic travel);
		rgb_t c;
		c = '{8'd128, 8'd128, 8'd128};
		if (travel && (motion == MOTION_TRAVEL || motion == MOTION_WIPE)) begin
			c = '{8'd56, 8'd72, 8'd155};
		end else begin
			case (role)
				8'd0:  c = '{8'd230, 8'd179, 8'd179};
				8'd1:  c = '{8'd255, 8'd230, 8'd77};
				8'd2:  c = '{8'd255, 8'd125, 8'd56};
				8'd3:  c = '{8'd31, 8'd31, 8'd255};
				8'd4:  c = '{8'd176, 8'd48, 8'd41};
				8'd5:  c = '{8'd150, 8'd84, 8'd204};
				8'd6:  c = '{8'd240, 8'd64, 8'd64};
				8'd7:  c = '{8'd102, 8'd92, 8'd199};
				8'd8:  c = '{8'd255, 8'd140, 8'd105};
				8'd9:  c = '{8'd77, 8'd128, 8'd186};
				8'd10: c = '{8'd77, 8'd128, 8'd186};
				8'd11: c = '{8'd255, 8'd255, 8'd255};
				8'd12: c = '{8'd0, 8'd135, 8'd110};
				8'd13: c = '{8'd0, 8'd59, 8'd110};
				8'd14: c = '{8'd0, 8'd255, 8'd0};
				8'd15: c = '{8'd0, 8'd128, 8'd0};
				8'd16: c = '{8'd0, 8'd64, 8'd0};
				8'd17: c = '{8'd179, 8'd227, 8'd171};
				8'd18: c = '{8'd94, 8'd209, 8'd148};
				8'd19: c = '{8'd128, 8'd128, 8'd128};
				8'd20: c = '{8'd26, 8'd173, 8'd196};
				8'd21: c = '{8'd0, 8'd104, 8'd122};
				8'd22: c = '{8'd220, 8'd150, 8'd95};
				default: c = '{8'd128, 8'd128, 8'd128};
			endcase
		end
		return c;
	endfunction

	// tool mod 5 by reciprocal multiply, exact for 16-bit ids
	function automatic rgb_t tool_rgb(input logic [15:0] tool);
		logic [32:0] prod;
		logic [14:0] quo;
		logic [17:0] rem;
		rgb_t c;
		prod = {17'd0, tool} * 33'd52429;
		quo  = prod[32:18];
		rem  = {2'd0, tool} - ({3'd0, quo} * 18'd5);
		if (tool == TOOL_NONE) begin
			rem = 18'd0;
		end
		case (rem[2:0])
			3'd1:    c = '{8'd242, 8'd117, 8'd89};
			3'd2:    c = '{8'd89, 8'd209, 8'd122};
			3'd3:    c = '{8'd198, 8'd127, 8'd242};
			3'd4:    c = '{8'd242, 8'd198, 8'd63};
			default: c = '{8'd63, 8'd168, 8'd237};
		endcase
		return c;
	endfunction

	function automatic rgb_t heat_stop(input logic [HEAT_IW-1:0] idx);
		rgb_t c;
		case (idx)
			4'd1:  c = '{8'd19, 8'd89, 8'd133};
			4'd2:  c = '{8'd28, 8'd136, 8'd145};
			4'd3:  c = '{8'd4, 8'd214, 8'd15};
			4'd4:  c = '{8'd170, 8'd242, 8'd0};
			4'd5:  c = '{8'd252, 8'd249, 8'd3};
			4'd6:  c = '{8'd245, 8'd206, 8'd10};
			4'd7:  c = '{8'd227, 8'd136, 8'd32};
			4'd8:  c = '{8'd209, 8'd104, 8'd48};
			4'd9:  c = '{8'd194, 8'd82, 8'd60};
			4'd10: c = '{8'd148, 8'd38, 8'd22};
			default: c = '{8'd11, 8'd44, 8'd122};
		endcase
		return c;
	endfunction

endpackage

/* src/segment_color_mapper_top.sv */
// Top level of the segment color mapper: front stages, divider and ramp.
//
// Colors one toolpath segment per request, one request per clock while
// in_stall is low, through three front stages (flow product partials,
// product sum with saturation, range offset and compare), FRAC_BITS
// divider stages that each settle one bit of the normalized heat value,
// and three ramp stages (segment pick, interpolation multiply, output
// register). The whole pipe advances as one; in_stall is high exactly
// while a finished result sits at the output and out_stall holds it.
// Role, tool and preview colors are resolved in the first stage and ride
// along with the heat math, so every mode has the same latency and
// results leave in request order. Configuration writes are always taken
// (cfg_ready is tied high); index 3 is ignored. Write the registers only
// while the pipe is empty.
module segment_color_mapper_top import smap_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] metric_value,
	input  logic [30:0] flow_factor,
	input  logic        no_deposition,
	input  logic [1:0]  motion_kind,
	input  logic [7:0]  extrusion_role,
	input  logic [15:0] tool_number,
	input  logic [23:0] preview_rgb,
	input  logic        preview_found,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        color_valid
);

	// config registers
	logic [2:0]         mode_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ROLE;
			min_q  <= 32'sd0;
			max_q  <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[2:0];
				CFG_MIN:  min_q  <= $signed(cfg_data);
				CFG_MAX:  max_q  <= $signed(cfg_data);
				default:  ;
			endcase
		end
	end

	// global advance: freeze everything while the output is held
	logic en;
	logic ramp_valid;

	assign en       = !(ramp_valid && out_stall);
	assign in_stall = !en;

	// stage 1: non-heat color, product partials
	side_t                side_c;
	logic                 vld_s1;
	logic                 flow_s1;
	logic signed [31:0]   metric_s1;
	logic signed [48:0]   pplo_s1;
	logic signed [47:0]   pphi_s1;
	side_t                side_s1;

	always_comb begin
		side_c.heat = (mode_q == MODE_HEAT) || (mode_q == MODE_FLOW);
		side_c.ok   = 1'b1;
		side_c.rgb  = role_rgb(extrusion_role, motion_kind, no_deposition);
		unique case (mode_q)
			MODE_PREVIEW: begin
				if (no_deposition) begin
					side_c.rgb = role_rgb(extrusion_role, motion_kind, 1'b1);
				end else if (preview_found) begin
					side_c.rgb = '{preview_rgb[23:16], preview_rgb[15:8], preview_rgb[7:0]};
				end else begin
					side_c.rgb = '0;
					side_c.ok  = 1'b0;
				end
			end
			MODE_TOOL: side_c.rgb = tool_rgb(tool_number);
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flow_s1   <= (mode_q == MODE_FLOW);
			metric_s1 <= $signed(metric_value);
			pplo_s1   <= 49'($signed(metric_value)) * 49'($signed({1'b0, flow_factor[15:0]}));
			pphi_s1   <= 48'($signed(metric_value)) * 48'($signed({1'b0, flow_factor[30:16]}));
			side_s1   <= side_c;
		end
	end

	// stage 2: product sum, floor shift by 16, saturate
	logic signed [63:0] prod;
	logic signed [47:0] shr;
	logic signed [31:0] sat;
	logic               vld_s2;
	logic signed [31:0] v_s2;
	side_t              side_s2;

	always_comb begin
		prod = 64'(pplo_s1) + (64'(pphi_s1) <<< 16);
		shr  = prod[63:16];
		if (shr > 48'sh7fffffff) begin
			sat = 32'sh7fffffff;
		end else if (shr < -48'sh80000000) begin
			sat = 32'sh80000000;
		end else begin
			sat = shr[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2    <= flow_s1 ? sat : metric_s1;
			side_s2 <= side_s1;
		end
	end

	// stage 3: offset into range, clamp flags
	logic signed [32:0] num;
	logic signed [32:0] den;
	logic               vld_s3;
	logic               zero_s3;
	logic               sat_s3;
	logic [31:0]        rem_s3;
	logic [31:0]        den_s3;
	side_t              side_s3;

	always_comb begin
		num = 33'(v_s2) - 33'(min_q);
		den = 33'(max_q) - 33'(min_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= (den <= 33'sd0) || (num <= 33'sd0);
			sat_s3  <= num >= den;
			rem_s3  <= num[31:0];
			den_s3  <= den[31:0];
			side_s3 <= side_s2;
		end
	end

	// divider and ramp
	logic               div_valid;
	logic [FRAC_BITS:0] div_t;
	side_t              div_side;
	rgb_t               ramp_rgb;
	logic               ramp_ok;

	smap_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_zero   (zero_s3),
		.in_sat    (sat_s3),
		.in_rem    (rem_s3),
		.in_den    (den_s3),
		.in_side   (side_s3),
		.out_valid (div_valid),
		.out_t     (div_t),
		.out_side  (div_side)
	);

	smap_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.in_t      (div_t),
		.in_side   (div_side),
		.out_valid (ramp_valid),
		.out_rgb   (ramp_rgb),
		.out_ok    (ramp_ok)
	);

	assign out_valid   = ramp_valid;
	assign red         = ramp_rgb.r;
	assign green       = ramp_rgb.g;
	assign blue        = ramp_rgb.b;
	assign color_valid = ramp_ok;

`ifndef SYNTH
	// a frozen pipe keeps its front valid bits
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({vld_s1, vld_s2, vld_s3}))
		else $error("front stages moved while held");

	// a missing color is reported as black
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !color_valid |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("invalid color is not black");

	// only preview mode can lack a color
	a_prev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !color_valid |-> mode_q == MODE_PREVIEW)
		else $error("invalid color outside preview mode");
`endif

endmodule

/* src/smap_div.sv */
// Pipelined restoring divider: one quotient bit per stage, gives t in [0,1].
module smap_div import smap_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic               in_zero,
	input  logic               in_sat,
	input  logic [31:0]        in_rem,
	input  logic [31:0]        in_den,
	input  side_t              in_side,
	output logic               out_valid,
	output logic [FRAC_BITS:0] out_t,
	output side_t              out_side
);

	logic                 vld_s  [0:FRAC_BITS];
	logic                 zero_s [0:FRAC_BITS];
	logic                 sat_s  [0:FRAC_BITS];
	logic [31:0]          rem_s  [0:FRAC_BITS];
	logic [31:0]          den_s  [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_s  [0:FRAC_BITS];
	side_t                side_s [0:FRAC_BITS];

	assign vld_s[0]  = in_valid;
	assign zero_s[0] = in_zero;
	assign sat_s[0]  = in_sat;
	assign rem_s[0]  = in_rem;
	assign den_s[0]  = in_den;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_step
		logic [32:0] dbl;
		logic [32:0] dif;
		logic        ge;

		always_comb begin
			dbl = {rem_s[j-1], 1'b0};
			dif = dbl - {1'b0, den_s[j-1]};
			ge  = dbl >= {1'b0, den_s[j-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[j] <= zero_s[j-1];
				sat_s[j]  <= sat_s[j-1];
				rem_s[j]  <= ge ? dif[31:0] : dbl[31:0];
				den_s[j]  <= den_s[j-1];
				quo_s[j]  <= {quo_s[j-1][FRAC_BITS-2:0], ge};
				side_s[j] <= side_s[j-1];
			end
		end
	end

	always_comb begin
		priority if (zero_s[FRAC_BITS]) begin
			out_t = '0;
		end else if (sat_s[FRAC_BITS]) begin
			out_t = {1'b1, {FRAC_BITS{1'b0}}};
		end else begin
			out_t = {1'b0, quo_s[FRAC_BITS]};
		end
	end

	assign out_valid = vld_s[FRAC_BITS];
	assign out_side  = side_s[FRAC_BITS];

endmodule

/* src/smap_ramp.sv */
// Heat ramp: segment pick, per-channel interpolation, output register.
module smap_ramp import smap_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [FRAC_BITS:0] in_t,
	input  side_t              in_side,
	output logic               out_valid,
	output rgb_t               out_rgb,
	output logic               out_ok
);

	localparam int GW = FRAC_BITS + 1 + HEAT_IW;
	localparam int PW = FRAC_BITS + 11;
	localparam logic [HEAT_IW:0] LAST_SEG = (HEAT_IW + 1)'(HEAT_STOPS - 2);

	// stage 1: g = t * (stops - 1), split into segment and fraction
	logic [GW-1:0]      g;
	logic [HEAT_IW:0]   seg_raw;
	logic [HEAT_IW:0]   seg;
	logic [GW-1:0]      kfull;
	logic               vld_s1;
	logic [HEAT_IW-1:0] seg_s1;
	logic [FRAC_BITS:0] k_s1;
	side_t              side_s1;

	always_comb begin
		g       = GW'(in_t) * GW'(HEAT_STOPS - 1);
		seg_raw = g[GW-1:FRAC_BITS];
		seg     = (seg_raw > LAST_SEG) ? LAST_SEG : seg_raw;
		kfull   = g - (GW'(seg) << FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1  <= seg[HEAT_IW-1:0];
			k_s1    <= kfull[FRAC_BITS:0];
			side_s1 <= in_side;
		end
	end

	// stage 2: (b - a) * k per channel
	rgb_t                  lo_c;
	rgb_t                  hi_c;
	logic signed [8:0]     dif [3];
	logic signed [PW-1:0]  prd [3];
	logic                  vld_s2;
	rgb_t                  base_s2;
	logic signed [PW-1:0]  prd_s2 [3];
	side_t                 side_s2;

	always_comb begin
		lo_c   = heat_stop(seg_s1);
		hi_c   = heat_stop(seg_s1 + HEAT_IW'(1));
		dif[0] = $signed({1'b0, hi_c.r}) - $signed({1'b0, lo_c.r});
		dif[1] = $signed({1'b0, hi_c.g}) - $signed({1'b0, lo_c.g});
		dif[2] = $signed({1'b0, hi_c.b}) - $signed({1'b0, lo_c.b});
		for (int c = 0; c < 3; c++) begin
			prd[c] = PW'(dif[c]) * PW'($signed({1'b0, k_s1}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2 <= lo_c;
			prd_s2  <= prd;
			side_s2 <= side_s1;
		end
	end

	// stage 3: floor(a + (b - a) * k), or the carried color
	logic signed [PW-1:0] acc [3];
	logic                 vld_s3;
	rgb_t                 rgb_s3;
	logic                 ok_s3;

	always_comb begin
		acc[0] = $signed(PW'({base_s2.r, {FRAC_BITS{1'b0}}})) + prd_s2[0];
		acc[1] = $signed(PW'({base_s2.g, {FRAC_BITS{1'b0}}})) + prd_s2[1];
		acc[2] = $signed(PW'({base_s2.b, {FRAC_BITS{1'b0}}})) + prd_s2[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s2.heat) begin
				rgb_s3 <= '{acc[0][FRAC_BITS+7:FRAC_BITS], acc[1][FRAC_BITS+7:FRAC_BITS],
					acc[2][FRAC_BITS+7:FRAC_BITS]};
				ok_s3  <= 1'b1;
			end else begin
				rgb_s3 <= side_s2.rgb;
				ok_s3  <= side_s2.ok;
			end
		end
	end

	assign out_valid = vld_s3;
	assign out_rgb   = rgb_s3;
	assign out_ok    = ok_s3;

endmodule
